// ----- hdl/rgma_pkg.sv -----
// ----------------------------------------------------------------------------
// rgma_pkg: shared types and constants
// Sizes, register indexes and lane control for the six-channel moving average.
// ----------------------------------------------------------------------------
package rgma_pkg;

	localparam int CHANNELS   = 6;
	localparam int MAX_WINDOW = 64;
	localparam int DATA_W     = 32;
	localparam int PTR_W      = $clog2(MAX_WINDOW);
	localparam int FILL_W     = PTR_W + 1;
	localparam int SUM_W      = DATA_W + PTR_W + 1;
	localparam int DIV_STEP   = 5;
	localparam int DIV_ITERS  = (SUM_W + DIV_STEP) / DIV_STEP;
	localparam int DVD_W      = DIV_ITERS * DIV_STEP;
	localparam int CNT_W      = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;
	localparam int WIN_REG_W  = 7;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_AVG_WINDOW    = CFG_IDX_W'(1);

	localparam logic [DATA_W-1:0]    PERIOD_RESET = DATA_W'(10000);
	localparam logic [WIN_REG_W-1:0] WINDOW_RESET = WIN_REG_W'(50);

	typedef logic signed [DATA_W-1:0] sample_t;

	typedef struct packed {
		logic              start;
		logic              capture;
		logic              pass_sel;
		logic              sum_en;
		logic              load_en;
		logic              div_en;
		logic              pop;
		logic [PTR_W-1:0]  wr_addr;
		logic [PTR_W-1:0]  rd_addr;
		logic [FILL_W-1:0] divisor;
	} lane_ctl_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SUM  = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

// ----- hdl/rgma_lane.sv -----
// ----------------------------------------------------------------------------
// rgma_lane: one channel of the moving average
// Sample ring, running sum and a radix-32 divider for sum / fill.
// ----------------------------------------------------------------------------
module rgma_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  rgma_pkg::lane_ctl_t ctl,
	input  rgma_pkg::sample_t   sample,
	output rgma_pkg::sample_t   result
);

	logic [rgma_pkg::DATA_W-1:0] mem [rgma_pkg::MAX_WINDOW];
	logic [rgma_pkg::DATA_W-1:0] rd_q;
	rgma_pkg::sample_t           samp_q;
	logic signed [rgma_pkg::SUM_W-1:0] sum_q;
	logic [rgma_pkg::DVD_W-1:0]  dvd_q;
	logic [rgma_pkg::FILL_W-1:0] rem_q;
	logic                        neg_q;

	logic signed [rgma_pkg::SUM_W-1:0] samp_ext;
	logic signed [rgma_pkg::SUM_W-1:0] old_ext;
	logic [rgma_pkg::SUM_W-1:0]        mag;
	logic [rgma_pkg::DVD_W-1:0]        dvd_n;
	logic [rgma_pkg::FILL_W-1:0]       rem_n;
	logic [rgma_pkg::DATA_W-1:0]       quo;

	// read old entry before the write lands (same address when the ring is full)
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rd_q <= mem[ctl.rd_addr];
			mem[ctl.wr_addr] <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture)
			samp_q <= sample;
	end

	assign samp_ext = {{(rgma_pkg::SUM_W-rgma_pkg::DATA_W){samp_q[rgma_pkg::DATA_W-1]}}, samp_q};
	assign old_ext  = ctl.pop ?
		{{(rgma_pkg::SUM_W-rgma_pkg::DATA_W){rd_q[rgma_pkg::DATA_W-1]}}, rd_q} :
		'0;
	assign mag = sum_q[rgma_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.sum_en) begin
			sum_q <= sum_q + samp_ext - old_ext;
		end
	end

	// restoring division, DIV_STEP quotient bits per cycle
	always_comb begin
		logic [rgma_pkg::FILL_W:0]  r;
		logic [rgma_pkg::DVD_W-1:0] d;
		r = {1'b0, rem_q};
		d = dvd_q;
		for (int j = 0; j < rgma_pkg::DIV_STEP; j++) begin
			r = {r[rgma_pkg::FILL_W-1:0], d[rgma_pkg::DVD_W-1]};
			d = {d[rgma_pkg::DVD_W-2:0], 1'b0};
			if (r >= {1'b0, ctl.divisor}) begin
				r = r - {1'b0, ctl.divisor};
				d[0] = 1'b1;
			end
		end
		rem_n = r[rgma_pkg::FILL_W-1:0];
		dvd_n = d;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_en) begin
			neg_q <= sum_q[rgma_pkg::SUM_W-1];
			dvd_q <= {{(rgma_pkg::DVD_W-rgma_pkg::SUM_W){1'b0}}, mag};
			rem_q <= '0;
		end else if (ctl.div_en) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
	end

	assign quo    = dvd_q[rgma_pkg::DATA_W-1:0];
	assign result = ctl.pass_sel ? samp_q : (neg_q ? -quo : quo);

endmodule

// ----- hdl/rate_gated_moving_average_6ch.sv -----
// ----------------------------------------------------------------------------
// rate_gated_moving_average_6ch: rate-gated six-channel boxcar average
// Tick gating, ring control, six parallel lanes and the output register.
// ----------------------------------------------------------------------------
// A tick is taken when in_valid is high and in_stall low. Ticks closer than
// update_period to the last accepted one are dropped with no result. An
// accepted averaging tick runs through a ring access, a sum update, a divider
// load, divider iterations of 5 quotient bits each and an output load; a
// pass-through tick (window 0 or 1) goes straight to the output load. The six
// lane dividers run side by side, so the divider iteration count sets the
// rate. The block takes one tick at a time; the output register lets the next
// tick in while a result waits. cfg_ready is always high; write configuration
// only while idle.
module rate_gated_moving_average_6ch (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rgma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgma_pkg::DATA_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rgma_pkg::DATA_W-1:0]     now_time,
	input  logic signed [rgma_pkg::DATA_W-1:0] lin_x,
	input  logic signed [rgma_pkg::DATA_W-1:0] lin_y,
	input  logic signed [rgma_pkg::DATA_W-1:0] lin_z,
	input  logic signed [rgma_pkg::DATA_W-1:0] ang_x,
	input  logic signed [rgma_pkg::DATA_W-1:0] ang_y,
	input  logic signed [rgma_pkg::DATA_W-1:0] ang_z,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [rgma_pkg::DATA_W-1:0] avg_lin_x,
	output logic signed [rgma_pkg::DATA_W-1:0] avg_lin_y,
	output logic signed [rgma_pkg::DATA_W-1:0] avg_lin_z,
	output logic signed [rgma_pkg::DATA_W-1:0] avg_ang_x,
	output logic signed [rgma_pkg::DATA_W-1:0] avg_ang_y,
	output logic signed [rgma_pkg::DATA_W-1:0] avg_ang_z
);

	rgma_pkg::state_t             state_q;
	logic [rgma_pkg::DATA_W-1:0]  period_q;
	logic [rgma_pkg::WIN_REG_W-1:0] window_q;
	logic [rgma_pkg::DATA_W-1:0]  last_q;
	logic [rgma_pkg::FILL_W-1:0]  fill_q;
	logic [rgma_pkg::PTR_W-1:0]   oldest_q;
	logic                         pop_q;
	logic                         pass_q;
	logic [rgma_pkg::CNT_W-1:0]   cnt_q;
	logic                         out_valid_q;
	rgma_pkg::sample_t            out_q [rgma_pkg::CHANNELS];

	rgma_pkg::sample_t            samp [rgma_pkg::CHANNELS];
	rgma_pkg::sample_t            res  [rgma_pkg::CHANNELS];
	rgma_pkg::lane_ctl_t          ctl;

	logic                         take;
	logic                         gate_ok;
	logic [rgma_pkg::DATA_W-1:0]  diff;
	logic [rgma_pkg::FILL_W-1:0]  win;
	logic [rgma_pkg::FILL_W:0]    fill_inc;
	logic                         pop;
	logic                         avg_go;
	logic                         pass_go;
	logic                         out_free;

	assign samp[0] = lin_x;
	assign samp[1] = lin_y;
	assign samp[2] = lin_z;
	assign samp[3] = ang_x;
	assign samp[4] = ang_y;
	assign samp[5] = ang_z;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != rgma_pkg::ST_IDLE);
	assign take      = in_valid && !in_stall;

	assign diff    = now_time - last_q;
	assign gate_ok = (period_q == '0) || (diff >= period_q);
	assign win     = (window_q > rgma_pkg::WIN_REG_W'(rgma_pkg::MAX_WINDOW)) ?
		rgma_pkg::FILL_W'(rgma_pkg::MAX_WINDOW) : rgma_pkg::FILL_W'(window_q);
	assign fill_inc = {1'b0, fill_q} + 1'b1;
	assign pop      = fill_inc > {1'b0, win};
	assign avg_go   = take && gate_ok && (win > rgma_pkg::FILL_W'(1));
	assign pass_go  = take && gate_ok && (win <= rgma_pkg::FILL_W'(1));
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		ctl.start    = avg_go;
		ctl.capture  = avg_go || pass_go;
		ctl.pass_sel = pass_go || pass_q;
		ctl.sum_en   = (state_q == rgma_pkg::ST_SUM);
		ctl.load_en  = (state_q == rgma_pkg::ST_LOAD);
		ctl.div_en   = (state_q == rgma_pkg::ST_DIV);
		ctl.pop      = pop_q;
		ctl.wr_addr  = oldest_q + fill_q[rgma_pkg::PTR_W-1:0];
		ctl.rd_addr  = oldest_q;
		ctl.divisor  = fill_q;
	end

	for (genvar c = 0; c < rgma_pkg::CHANNELS; c++) begin : g_lane
		rgma_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sample (samp[c]),
			.result (res[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= rgma_pkg::PERIOD_RESET;
			window_q <= rgma_pkg::WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rgma_pkg::REG_UPDATE_PERIOD: period_q <= cfg_data;
				rgma_pkg::REG_AVG_WINDOW:    window_q <= cfg_data[rgma_pkg::WIN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rgma_pkg::ST_IDLE;
			last_q      <= '0;
			fill_q      <= '0;
			oldest_q    <= '0;
			pop_q       <= 1'b0;
			pass_q      <= 1'b0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				rgma_pkg::ST_IDLE: begin
					if (take && gate_ok)
						last_q <= now_time;
					if (avg_go) begin
						pop_q   <= pop;
						pass_q  <= 1'b0;
						state_q <= rgma_pkg::ST_SUM;
						if (pop)
							oldest_q <= oldest_q + 1'b1;
						else
							fill_q <= fill_inc[rgma_pkg::FILL_W-1:0];
					end else if (pass_go) begin
						pass_q  <= 1'b1;
						state_q <= rgma_pkg::ST_DONE;
					end
				end
				rgma_pkg::ST_SUM:  state_q <= rgma_pkg::ST_LOAD;
				rgma_pkg::ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= rgma_pkg::ST_DIV;
				end
				rgma_pkg::ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == rgma_pkg::CNT_W'(rgma_pkg::DIV_ITERS - 1))
						state_q <= rgma_pkg::ST_DONE;
				end
				rgma_pkg::ST_DONE: begin
					// hold until the output register frees up
					if (out_free) begin
						pass_q  <= 1'b0;
						state_q <= rgma_pkg::ST_IDLE;
					end
				end
				default: state_q <= rgma_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rgma_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rgma_pkg::ST_DONE && out_free) begin
			for (int c = 0; c < rgma_pkg::CHANNELS; c++)
				out_q[c] <= res[c];
		end
	end

	assign out_valid = out_valid_q;
	assign avg_lin_x = out_q[0];
	assign avg_lin_y = out_q[1];
	assign avg_lin_z = out_q[2];
	assign avg_ang_x = out_q[3];
	assign avg_ang_y = out_q[4];
	assign avg_ang_z = out_q[5];

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= rgma_pkg::FILL_W'(rgma_pkg::MAX_WINDOW))
		else $error("fill count above capacity");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == rgma_pkg::ST_DONE))
		else $error("result shown without a finished transaction");

	a_sum_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rgma_pkg::ST_SUM) |-> $past(state_q == rgma_pkg::ST_IDLE))
		else $error("sum update outside a new transaction");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for rate_gated_moving_average_6ch
// A directed table (extremes, drop window, time wrap, pass-through, window
// above capacity and window shrink) runs first, then about 850 random ticks
// over changing register settings. Random idle on the input side and random
// stall on the output side stop in two calm phases. Every accepted result
// is compared field by field with a behavioral boxcar-average predictor.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 850;
	localparam int EXP_DEPTH = 256;

	typedef logic [rgma_pkg::CHANNELS-1:0][rgma_pkg::DATA_W-1:0] chan_vec_t;

	typedef struct packed {
		logic [rgma_pkg::DATA_W-1:0] now;
		chan_vec_t                   smp;
	} tick_t;

	typedef enum logic [1:0] {ROW_CHECK, ROW_DROP, ROW_RAW, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                      kind;
		logic [rgma_pkg::CFG_IDX_W-1:0] idx;
		logic [rgma_pkg::DATA_W-1:0]    data;
		tick_t                          tick;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rgma_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rgma_pkg::DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [rgma_pkg::DATA_W-1:0] now_time = '0;
	logic signed [rgma_pkg::DATA_W-1:0] lin_x = '0, lin_y = '0, lin_z = '0;
	logic signed [rgma_pkg::DATA_W-1:0] ang_x = '0, ang_y = '0, ang_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [rgma_pkg::DATA_W-1:0] avg_lin_x, avg_lin_y, avg_lin_z;
	logic signed [rgma_pkg::DATA_W-1:0] avg_ang_x, avg_ang_y, avg_ang_z;

	rate_gated_moving_average_6ch u_dut (.*);

	always #10 clk = ~clk;

	// predictor state
	logic [rgma_pkg::DATA_W-1:0]    period_q;
	logic [rgma_pkg::WIN_REG_W-1:0] window_q;
	logic [rgma_pkg::DATA_W-1:0]    last_time;
	logic signed [rgma_pkg::DATA_W-1:0] ring [rgma_pkg::CHANNELS][rgma_pkg::MAX_WINDOW];
	longint               sums [rgma_pkg::CHANNELS];
	int unsigned          fill;
	int unsigned          oldest;

	// expected results, in order
	chan_vec_t   exp_mem [EXP_DEPTH];
	int unsigned exp_wr = 0;
	int unsigned exp_rd = 0;

	int        n_errors = 0;
	int        n_ticks = 0;
	int        n_dropped = 0;
	int        n_results = 0;
	bit        calm = 1'b0;
	logic [rgma_pkg::DATA_W-1:0] prev_now = '0;

	string chan_name [rgma_pkg::CHANNELS] = '{"avg_lin_x", "avg_lin_y", "avg_lin_z",
		"avg_ang_x", "avg_ang_y", "avg_ang_z"};

	// Returns 1 and the averages when the tick passes the rate gate.
	function automatic bit average_tick(input tick_t t, output chan_vec_t avg);
		int unsigned win, wpos;
		bit pop;
		longint q;
		avg = '0;
		if (period_q != 0 && (t.now - last_time) < period_q)
			return 1'b0;
		last_time = t.now;
		win = (window_q > rgma_pkg::MAX_WINDOW) ? rgma_pkg::MAX_WINDOW : window_q;
		if (win <= 1) begin
			avg = t.smp;
			return 1'b1;
		end
		pop = (fill + 1) > win;
		wpos = oldest + fill;
		if (wpos >= rgma_pkg::MAX_WINDOW)
			wpos -= rgma_pkg::MAX_WINDOW;
		if (wpos >= rgma_pkg::MAX_WINDOW)
			wpos = 0;
		for (int c = 0; c < rgma_pkg::CHANNELS; c++) begin
			sums[c] += longint'($signed(t.smp[c]));
			if (pop)
				sums[c] -= longint'(ring[c][oldest]);
			ring[c][wpos] = $signed(t.smp[c]);
		end
		if (pop)
			oldest = (oldest + 1 >= rgma_pkg::MAX_WINDOW) ?
				oldest + 1 - rgma_pkg::MAX_WINDOW : oldest + 1;
		else
			fill++;
		for (int c = 0; c < rgma_pkg::CHANNELS; c++) begin
			q = sums[c] / longint'(fill);
			avg[c] = q[rgma_pkg::DATA_W-1:0];
		end
		return 1'b1;
	endfunction

	function automatic void expect_add(input chan_vec_t v);
		exp_mem[exp_wr % EXP_DEPTH] = v;
		exp_wr++;
	endfunction

	always @(posedge clk)
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);

	// result checker
	always @(posedge clk) begin
		chan_vec_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {avg_ang_z, avg_ang_y, avg_ang_x, avg_lin_z, avg_lin_y, avg_lin_x};
			n_results++;
			if (exp_wr == exp_rd) begin
				$error("unexpected result transaction");
				n_errors++;
			end else begin
				want = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				for (int c = 0; c < rgma_pkg::CHANNELS; c++)
					if (got[c] !== want[c]) begin
						$error("%s: expected %h, got %h", chan_name[c], want[c], got[c]);
						n_errors++;
					end
			end
		end
	end

	task automatic send_tick(input tick_t t, input row_kind_t kind);
		chan_vec_t avg;
		bit hit;
		if (!calm && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		now_time <= t.now;
		{ang_z, ang_y, ang_x, lin_z, lin_y, lin_x} <= t.smp;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		prev_now = t.now;
		n_ticks++;
		hit = average_tick(t, avg);
		if (kind == ROW_DROP) begin
			if (hit) begin
				$error("tick at time %h should fall inside the drop window", t.now);
				n_errors++;
			end
		end else if (kind == ROW_RAW)
			expect_add(t.smp);
		else if (hit)
			expect_add(avg);
		if (!hit)
			n_dropped++;
	endtask

	// Drain results, then allow for a dropped tick still in flight.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rgma_pkg::CFG_IDX_W-1:0] idx,
			input logic [rgma_pkg::DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == rgma_pkg::REG_UPDATE_PERIOD)
			period_q = data;
		else if (idx == rgma_pkg::REG_AVG_WINDOW)
			window_q = data[rgma_pkg::WIN_REG_W-1:0];
		@(posedge clk);
	endtask

	function automatic row_t tick_row(row_kind_t k, logic [31:0] now, logic [31:0] a,
			logic [31:0] b);
		row_t r;
		r = '0;
		r.kind = k;
		r.tick.now = now;
		r.tick.smp = {b, b ^ 32'h1, b, a, a ^ 32'h1, a};
		return r;
	endfunction

	function automatic row_t cfg_row(logic [rgma_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF - $urandom_range(3);
			1: return 32'h8000_0000 + $urandom_range(3);
			2: return 32'($signed($urandom_range(2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		row_t dir [$];
		tick_t t;
		int unsigned step;
		// pristine reset values
		period_q = rgma_pkg::PERIOD_RESET;
		window_q = rgma_pkg::WINDOW_RESET;
		last_time = '0;
		fill = 0;
		oldest = 0;
		foreach (sums[c]) sums[c] = 0;

		// within-window drop right after reset, then the gate opens
		dir = {dir, tick_row(ROW_DROP, 32'd0, 32'h1, 32'h2)};
		dir = {dir, tick_row(ROW_DROP, 32'd9999, 32'h3, 32'h4)};
		dir = {dir, tick_row(ROW_RAW, 32'd10000, 32'h7FFF_FFFF, 32'h8000_0000)};
		dir = {dir, tick_row(ROW_CHECK, 32'd20000, 32'h8000_0000, 32'h7FFF_FFFF)};
		dir = {dir, tick_row(ROW_CHECK, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h1)};
		// time wrap: 21 ticks after the last one
		dir = {dir, tick_row(ROW_DROP, 32'd5, 32'h5, 32'h6)};
		dir = {dir, tick_row(ROW_CHECK, 32'd10005, 32'h0, 32'h0)};
		// pass-through keeps the ring untouched
		dir = {dir, cfg_row(rgma_pkg::REG_UPDATE_PERIOD, 32'd0)};
		dir = {dir, cfg_row(rgma_pkg::REG_AVG_WINDOW, 32'd0)};
		dir = {dir, tick_row(ROW_RAW, 32'd10005, 32'h7FFF_FFFF, 32'h8000_0000)};
		dir = {dir, tick_row(ROW_RAW, 32'd0, 32'h8000_0000, 32'hFFFF_FFFF)};
		dir = {dir, cfg_row(rgma_pkg::REG_AVG_WINDOW, 32'd1)};
		dir = {dir, tick_row(ROW_RAW, 32'hFFFF_FFFF, 32'h1234_5678, 32'hEDCB_A988)};
		// window above capacity acts as the full ring
		dir = {dir, cfg_row(rgma_pkg::REG_AVG_WINDOW, 32'hFFFF_FF7F)};
		dir = {dir, tick_row(ROW_CHECK, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF)};
		dir = {dir, tick_row(ROW_CHECK, 32'd2, 32'h8000_0000, 32'h8000_0000)};
		dir = {dir, tick_row(ROW_CHECK, 32'd3, 32'hFFFF_FFFF, 32'h0000_0001)};
		dir = {dir, tick_row(ROW_CHECK, 32'd4, 32'h0000_0003, 32'hFFFF_FFFD)};
		// shrink the window: one sample leaves per tick
		dir = {dir, cfg_row(rgma_pkg::REG_AVG_WINDOW, 32'd2)};
		dir = {dir, tick_row(ROW_CHECK, 32'd5, 32'h0001_0000, 32'hFFFF_0000)};
		dir = {dir, tick_row(ROW_CHECK, 32'd6, 32'h7FFF_FFFF, 32'h8000_0000)};
		dir = {dir, tick_row(ROW_CHECK, 32'd7, 32'h8000_0000, 32'h7FFF_FFFF)};
		dir = {dir, cfg_row(rgma_pkg::REG_UPDATE_PERIOD, 32'hFFFF_FFFF)};
		dir = {dir, tick_row(ROW_CHECK, 32'd8, 32'h11, 32'h22)};
		dir = {dir, tick_row(ROW_CHECK, 32'd6, 32'h33, 32'h44)};
		dir = {dir, tick_row(ROW_CHECK, 32'd5, 32'h55, 32'h66)};
		dir = {dir, cfg_row(rgma_pkg::REG_AVG_WINDOW, 32'd64)};
		dir = {dir, tick_row(ROW_CHECK, 32'd4, 32'h77, 32'h88)};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i]) begin
			if (dir[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(dir[i].idx, dir[i].data);
			end else
				send_tick(dir[i].tick, dir[i].kind);
		end

		for (int ph = 0; ph < 17; ph++) begin
			wait_idle();
			case ($urandom_range(5))
				0: write_reg(rgma_pkg::REG_UPDATE_PERIOD, 32'hFFFF_FFFF);
				1: write_reg(rgma_pkg::REG_UPDATE_PERIOD, $urandom_range(1, 50));
				2: write_reg(rgma_pkg::REG_UPDATE_PERIOD, $urandom);
				default: write_reg(rgma_pkg::REG_UPDATE_PERIOD, 32'd0);
			endcase
			case ($urandom_range(6))
				0: write_reg(rgma_pkg::REG_AVG_WINDOW, $urandom_range(0, 1));
				1: write_reg(rgma_pkg::REG_AVG_WINDOW, 32'd64);
				2: write_reg(rgma_pkg::REG_AVG_WINDOW,
					($urandom & 32'hFFFF_FF80) | $urandom_range(65, 127));
				3: write_reg(rgma_pkg::REG_AVG_WINDOW, $urandom_range(2, 4));
				default: write_reg(rgma_pkg::REG_AVG_WINDOW, $urandom_range(2, 64));
			endcase
			calm = (ph == 8 || ph == 9);
			for (int k = 0; k < N_RANDOM / 17; k++) begin
				// mostly ticks that just clear the gate, some that fall short
				case ($urandom_range(7))
					0: step = $urandom;
					1: step = (period_q > 1) ? $urandom_range(period_q - 1, 0) : 0;
					default: step = period_q + $urandom_range(2);
				endcase
				t.now = prev_now + step;
				for (int c = 0; c < rgma_pkg::CHANNELS; c++)
					t.smp[c] = rand_sample();
				send_tick(t, ROW_CHECK);
			end
		end
		calm = 1'b0;
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Ran %0d ticks (%0d dropped by the rate gate), checked %0d results.",
			n_ticks, n_dropped, n_results);
		$display("Covered pass-through, window above capacity, window shrink and time wrap.");
		if (n_errors == 0 && exp_wr == exp_rd)
			$display("rate_gated_moving_average_6ch: match");
		else begin
			if (exp_wr != exp_rd)
				$error("%0d expected results never arrived", exp_wr - exp_rd);
			$display("rate_gated_moving_average_6ch: mismatch");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("rate_gated_moving_average_6ch: mismatch");
		$finish;
	end

endmodule
